@@ rtl/core/dap_pkg.sv @@
// Shared types and constants for the decimal amount parser.
// No dependencies; compiled before every other file of the block.
package dap_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SCALE_W     = 5;
  localparam int unsigned VALUE_W     = 63;
  localparam int unsigned AMOUNT_W    = 64;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned MAC_W       = VALUE_W + 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_PLUS,
    TK_MINUS,
    TK_POINT,
    TK_END,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t           kind;
    logic [DIGIT_W-1:0]  digit;
  } token_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_INT    = 3'd2,
    PH_FRAC   = 3'd3,
    PH_BAD    = 3'd4
  } phase_t;

  typedef enum logic {
    ST_RUN,
    ST_PAD
  } ctl_state_t;

endpackage

@@ rtl/core/dap_char_if.sv @@
// Character channel: valid/ready handshake carrying one byte per transaction.
// Depends on dap_pkg.
interface dap_char_if import dap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

@@ rtl/core/dap_result_if.sv @@
// Result channel: valid/ready handshake carrying amount and ok flag.
// Depends on dap_pkg.
interface dap_result_if import dap_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [AMOUNT_W-1:0] amount;
  logic                       ok;

  modport source (output valid, output amount, output ok, input ready);
  modport sink   (input valid, input amount, input ok, output ready);
endinterface

@@ rtl/core/dap_front.sv @@
// Front end: takes character transactions and classifies them into tokens.
// Depends on dap_pkg and dap_char_if; feeds dap_queue.
module dap_front import dap_pkg::*; (
  dap_char_if.sink chars,
  output logic     push_valid,
  output token_t   push_tok,
  input  logic     push_ready
);

  logic [CHAR_W-1:0] c;

  assign c           = chars.char_code;
  assign chars.ready = push_ready;
  assign push_valid  = chars.valid;

  always_comb begin
    push_tok.digit = '0;
    if (c == CH_NUL) begin
      push_tok.kind = TK_END;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      push_tok.kind  = TK_DIGIT;
      push_tok.digit = DIGIT_W'(c - CH_ZERO);
    end else if (c == CH_PLUS) begin
      push_tok.kind = TK_PLUS;
    end else if (c == CH_MINUS) begin
      push_tok.kind = TK_MINUS;
    end else if (c == CH_POINT || c == CH_COMMA) begin
      push_tok.kind = TK_POINT;
    end else begin
      push_tok.kind = TK_OTHER;
    end
  end

endmodule

@@ rtl/core/dap_queue.sv @@
// Short token queue decoupling the front end from the back end.
// Depends on dap_pkg.
module dap_queue import dap_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  input  token_t push_tok,
  output logic   push_ready,
  output logic   pop_valid,
  output token_t pop_tok,
  input  logic   pop
);

  token_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_tok    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/dap_back.sv @@
// Back end: runs the parse on queued tokens, pads to scale, holds the result.
// Depends on dap_pkg and dap_result_if; fed by dap_queue.
module dap_back import dap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [SCALE_W-1:0] scale,
  input  logic               tok_valid,
  input  token_t             tok,
  output logic               pop,
  dap_result_if.source       results
);

  ctl_state_t          ctl_state, ctl_state_next;
  phase_t              phase, phase_next;
  logic [VALUE_W-1:0]  value, value_next;
  logic                neg, neg_next;
  logic [SCALE_W-1:0]  fcount, fcount_next;
  logic                good, good_next;
  logic                res_valid;
  logic signed [AMOUNT_W-1:0] res_amount;
  logic                res_ok;

  logic [DIGIT_W-1:0]  mac_digit;
  logic [MAC_W-1:0]    mac;
  logic                mac_ovf;
  logic                pad_more;
  logic                pad_step;
  logic                load;
  logic                slot_free;
  logic [AMOUNT_W-1:0] mag;

  // value * 10 + digit, overflow when it leaves the 63-bit range
  assign mac_digit = (ctl_state == ST_RUN) ? tok.digit : '0;
  assign mac       = ({4'b0, value} << 3) + ({4'b0, value} << 1) + MAC_W'(mac_digit);
  assign mac_ovf   = |mac[MAC_W-1:VALUE_W];
  assign pad_more  = good && (fcount < scale);
  assign slot_free = !res_valid || results.ready;
  assign mag       = {1'b0, value};

  // controller next state
  always_comb begin
    ctl_state_next = ctl_state;
    case (ctl_state)
      ST_RUN: begin
        if (tok_valid && tok.kind == TK_END) ctl_state_next = ST_PAD;
      end
      ST_PAD: begin
        if (!pad_more && slot_free) ctl_state_next = ST_RUN;
      end
      default: ctl_state_next = ST_RUN;
    endcase
  end

  // controller outputs
  always_comb begin
    pop      = 1'b0;
    pad_step = 1'b0;
    load     = 1'b0;
    case (ctl_state)
      ST_RUN: pop = tok_valid;
      ST_PAD: begin
        pad_step = pad_more;
        load     = !pad_more && slot_free;
      end
      default: ;
    endcase
  end

  // parse datapath
  always_comb begin
    phase_next  = phase;
    value_next  = value;
    neg_next    = neg;
    fcount_next = fcount;
    good_next   = good;
    if (pop) begin
      if (tok.kind == TK_END) begin
        good_next = (phase == PH_INT) || (phase == PH_FRAC);
      end else begin
        case (phase)
          PH_START, PH_SIGNED: begin
            if (phase == PH_START && (tok.kind == TK_PLUS || tok.kind == TK_MINUS)) begin
              neg_next   = (tok.kind == TK_MINUS);
              phase_next = PH_SIGNED;
            end else if (tok.kind == TK_DIGIT && !mac_ovf) begin
              value_next = mac[VALUE_W-1:0];
              phase_next = PH_INT;
            end else begin
              phase_next = PH_BAD;
            end
          end
          PH_INT: begin
            if (tok.kind == TK_DIGIT) begin
              if (mac_ovf) phase_next = PH_BAD;
              else value_next = mac[VALUE_W-1:0];
            end else if (tok.kind == TK_POINT) begin
              phase_next = PH_FRAC;
            end else begin
              phase_next = PH_BAD;
            end
          end
          PH_FRAC: begin
            if (tok.kind != TK_DIGIT || fcount >= scale || mac_ovf) begin
              phase_next = PH_BAD;
            end else begin
              value_next  = mac[VALUE_W-1:0];
              fcount_next = fcount + 1'b1;
            end
          end
          default: phase_next = PH_BAD;
        endcase
      end
    end else if (pad_step) begin
      if (mac_ovf) begin
        good_next = 1'b0;
      end else begin
        value_next  = mac[VALUE_W-1:0];
        fcount_next = fcount + 1'b1;
      end
    end else if (load) begin
      phase_next  = PH_START;
      value_next  = '0;
      neg_next    = 1'b0;
      fcount_next = '0;
      good_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_state <= ST_RUN;
      phase     <= PH_START;
      value     <= '0;
      neg       <= 1'b0;
      fcount    <= '0;
      good      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      ctl_state <= ctl_state_next;
      phase     <= phase_next;
      value     <= value_next;
      neg       <= neg_next;
      fcount    <= fcount_next;
      good      <= good_next;
      if (load) res_valid <= 1'b1;
      else if (results.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_ok     <= good;
      res_amount <= !good ? '0 : (neg ? -$signed(mag) : $signed(mag));
    end
  end

  assign results.valid  = res_valid;
  assign results.amount = res_amount;
  assign results.ok     = res_ok;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ok) |-> (res_amount == '0))
    else $error("rejected result carries a non-zero amount");

  a_no_pop_in_pad: assert property (@(posedge clk) disable iff (rst)
    (ctl_state == ST_PAD) |-> !pop)
    else $error("token popped while padding");

  a_pad_counts: assert property (@(posedge clk) disable iff (rst)
    (pad_step && !mac_ovf) |=> (fcount == $past(fcount) + 1'b1))
    else $error("padding step did not advance the fraction count");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    load |=> (phase == PH_START && value == '0 && fcount == '0 && res_valid))
    else $error("parse state not cleared after result load");

endmodule

@@ rtl/core/decimal_amount_parser.sv @@
// Decimal amount parser, top level: scale register, front end, queue, back end.
// Depends on dap_pkg, dap_char_if, dap_result_if, dap_front, dap_queue, dap_back.
//
// Feed one character byte per transaction on chars; a zero byte ends the string
// and produces exactly one transaction on results with the signed amount in minor
// units and an ok flag (amount is zero when ok is low). Accepted form: optional
// '+' or '-', one or more integer digits, optionally '.' or ',' and up to scale
// fraction digits; anything else, or a value above 2^63-1, rejects the string.
// Back end: every non-terminating character is popped and goes through one
// multiply-by-ten-and-add with overflow check. A valid terminator is popped,
// then takes one padding step per missing fraction digit through the same
// multiply-by-ten unit, then loads the output register; padding stops early
// on overflow, a rejected string needs only the pop and the load, and the
// load waits while an earlier result is still held. A four-entry token
// queue lets characters keep arriving while the back end pads, and the
// output register lets the next string start while a result still waits to
// be taken. The scale register (reset 2) is written through cfg_we /
// cfg_wdata and must only change while the block is idle.

module decimal_amount_parser import dap_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  dap_char_if.sink           chars,
  dap_result_if.source       results
);

  logic [SCALE_W-1:0] scale;

  // front end to queue
  logic   push_valid;
  logic   push_ready;
  token_t push_tok;

  // queue to back end
  logic   pop_valid;
  logic   pop;
  token_t pop_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  // classify each byte into a token
  dap_front u_front (
    .chars      (chars),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .push_ready (push_ready)
  );

  // decoupling queue
  dap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_tok    (pop_tok),
    .pop        (pop)
  );

  // parse, pad, sign and hold the result
  dap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .scale     (scale),
    .tok_valid (pop_valid),
    .tok       (pop_tok),
    .pop       (pop),
    .results   (results)
  );

endmodule

@@ test/decimal_amount_parser_test.sv @@
// Self-checking testbench for decimal_amount_parser: directed strings, then random traffic.
// Depends on dap_pkg, dap_char_if, dap_result_if and the decimal_amount_parser RTL.
// Carries its own parser model, one result queue and a field-by-field result checker.
module decimal_amount_parser_test;
  import dap_pkg::*;

  // Magnitude ceiling, 2^63-1, and the radix used for every digit step.
  localparam logic [AMOUNT_W-1:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [AMOUNT_W-1:0] RADIX   = 64'd10;
  // Longest terminator is scale 31 with no fraction digits; settle time rounded up.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 475;

  typedef struct {
    logic [AMOUNT_W-1:0] amount;
    logic                ok;
  } amount_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;

  dap_char_if   chars_if ();
  dap_result_if results_if ();

  decimal_amount_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chars     (chars_if),
    .results   (results_if)
  );

  // Model of the parser: scale register plus the per-string parse state.
  logic [SCALE_W-1:0] scale_reg;
  logic [VALUE_W-1:0] mag;
  logic               neg_seen;
  phase_t             cur_phase;
  logic [SCALE_W-1:0] frac_cnt;

  amount_result_t      pending_results[$];
  logic [CHAR_W-1:0]   line_buf[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          chars_sent;
  int          strings_checked;
  int          strings_ok;
  int          mismatches;

  always #5 clk = ~clk;

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic logic digit_fits(input logic [VALUE_W-1:0] m, input logic [3:0] d);
    return {1'b0, m} <= (MAG_MAX - AMOUNT_W'(d)) / RADIX;
  endfunction

  function automatic logic [VALUE_W-1:0] shift_in(input logic [VALUE_W-1:0] m,
                                                  input logic [3:0] d);
    return VALUE_W'({1'b0, m} * RADIX + AMOUNT_W'(d));
  endfunction

  function automatic void clear_parse();
    mag       = '0;
    neg_seen  = 1'b0;
    cur_phase = PH_START;
    frac_cnt  = '0;
  endfunction

  // Advance the model by one accepted character; a terminator queues one result.
  function automatic void parse_char(input logic [CHAR_W-1:0] c);
    logic                is_digit;
    logic [3:0]          d;
    logic                good;
    logic [AMOUNT_W-1:0] v;
    int                  fc;
    amount_result_t      r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
    if (c == CH_NUL) begin
      // Only a string with integer digits can succeed; then pad up to the scale.
      good = (cur_phase == PH_INT) || (cur_phase == PH_FRAC);
      v = {1'b0, mag};
      fc = frac_cnt;
      while (good && fc < scale_reg) begin
        if (v > MAG_MAX / RADIX) begin
          good = 1'b0;
        end else begin
          v = v * RADIX;
          fc++;
        end
      end
      r.ok = good;
      r.amount = good ? (neg_seen ? -v : v) : '0;
      pending_results.push_back(r);
      clear_parse();
    end else begin
      case (cur_phase)
        PH_START, PH_SIGNED: begin
          // Sign allowed only as the first character.
          if (cur_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
            neg_seen = (c == CH_MINUS);
            cur_phase = PH_SIGNED;
          end else if (is_digit && digit_fits(mag, d)) begin
            mag = shift_in(mag, d);
            cur_phase = PH_INT;
          end else begin
            cur_phase = PH_BAD;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            if (digit_fits(mag, d)) mag = shift_in(mag, d);
            else cur_phase = PH_BAD;
          end else if (c == CH_POINT || c == CH_COMMA) begin
            cur_phase = PH_FRAC;
          end else begin
            cur_phase = PH_BAD;
          end
        end
        PH_FRAC: begin
          if (!is_digit || frac_cnt >= scale_reg || !digit_fits(mag, d)) begin
            cur_phase = PH_BAD;
          end else begin
            mag = shift_in(mag, d);
            frac_cnt++;
          end
        end
        default: begin
          // Rejected: swallow everything up to the terminator.
          cur_phase = PH_BAD;
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One character transaction. Idle gap first (valid low), then hold valid until
  // accepted. Valid is left high so back-to-back characters need no toggle.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      chars_if.valid <= 1'b0;
    end
    @(negedge clk);
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    do @(posedge clk); while (!chars_if.ready);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // Sender goes quiet until every predicted result has been taken, then lets
  // the back end finish any padding before anything else happens.
  task automatic wait_results_done();
    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Scale changes only with the block idle.
  task automatic set_scale(input logic [SCALE_W-1:0] s);
    wait_results_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we    <= 1'b0;
    scale_reg = s;
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    results_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    amount_result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got amount %0d ok %0b",
                 $time, $signed(results_if.amount), results_if.ok);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        strings_checked++;
        if (want.ok) strings_ok++;
        if (results_if.amount !== want.amount) begin
          $display("%0t: amount mismatch, expected %0d, got %0d", $time,
                   $signed(want.amount), $signed(results_if.amount));
          mismatches++;
        end
        if (results_if.ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, results_if.ok);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random string builder
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CHAR_W'(CH_ZERO + $urandom_range(9));
  endfunction

  // Mostly well-formed amounts with random content; some with one character
  // corrupted; the rest pure noise (any non-zero byte).
  task automatic compose_line();
    int unsigned pick;
    int unsigned n_int;
    int unsigned n_frac;
    int unsigned pos;
    string       near_max;
    near_max = "92233720368547758";
    line_buf.delete();
    pick = $urandom_range(99);
    if (pick < 85) begin
      case ($urandom_range(2))
        1: line_buf.push_back(CH_PLUS);
        2: line_buf.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(9) == 0) begin
        // Nineteen digits hugging 2^63-1: overflow either way of the edge.
        for (int i = 0; i < near_max.len(); i++) line_buf.push_back(near_max[i]);
        line_buf.push_back(rand_digit());
        line_buf.push_back(rand_digit());
      end else begin
        n_int = ($urandom_range(3) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
        repeat (n_int) line_buf.push_back(rand_digit());
      end
      if ($urandom_range(1)) begin
        line_buf.push_back($urandom_range(1) ? CH_POINT : CH_COMMA);
        // One more than the scale now and then, to trip the fraction limit.
        n_frac = $urandom_range(scale_reg + 1);
        repeat (n_frac) line_buf.push_back(rand_digit());
      end
      if (pick >= 70) begin
        pos = $urandom_range(line_buf.size() - 1);
        line_buf[pos] = CHAR_W'($urandom_range(255, 1));
      end
    end else begin
      repeat ($urandom_range(6)) line_buf.push_back(CHAR_W'($urandom_range(255, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset scale (2): signs, both separators, empty string and lone signs.
  task automatic test_signs_and_separators();
    send_text("");
    send_text("-");
    send_text("+");
    send_text("+7");
    send_text("-12.");
    send_text("1,5");
    send_text("-0.07");
  endtask

  // Rejections at scale 2: too many fraction digits, stray characters,
  // no integer digit, and overflow during padding.
  task automatic test_rejects();
    send_text("0.123");
    send_text("1x2");
    send_text(".5");
    send_text("-+1");
    send_text("12a");
    send_text("92233720368547758");
    send_text("92233720368547759");
  endtask

  // Scale extremes: full 63-bit range at 0, eighteen places, then 31 where
  // only zero survives padding.
  task automatic test_scale_extremes();
    set_scale(5'd0);
    send_text("9223372036854775807");
    send_text("-9223372036854775807");
    send_text("9223372036854775808");
    send_text("1.5");
    send_text("3.");
    set_scale(5'd18);
    send_text("9.223372036854775807");
    send_text("9.3");
    set_scale(5'd31);
    send_text("0");
    send_text("-0,0");
    send_text("1");
  endtask

  // One random phase at a given scale and idling mix; halfway through the
  // sender stops until every result is back.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [SCALE_W-1:0] s, input int n_items);
    int start_count;
    logic paused;
    set_scale(s);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count = chars_sent;
    paused = 1'b0;
    while (chars_sent - start_count < n_items) begin
      compose_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
      send_char(CH_NUL);
      if (!paused && chars_sent - start_count >= n_items / 2) begin
        wait_results_done();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    chars_if.valid = 1'b0;
    chars_if.char_code = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    chars_sent = 0;
    strings_checked = 0;
    strings_ok = 0;
    mismatches = 0;
    scale_reg = SCALE_RESET;
    clear_parse();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_signs_and_separators();
    test_rejects();
    test_scale_extremes();
    test_random_traffic(0, 0, 5'd2, RANDOM_ITEMS);
    test_random_traffic(51, 0, 5'd0, RANDOM_ITEMS);
    test_random_traffic(0, 51, 5'd18, RANDOM_ITEMS);
    test_random_traffic(8, 8, 5'd6, RANDOM_ITEMS);
    wait_results_done();

    $display("Ran %0d characters at scales 0, 2, 6, 18 and 31 under four idling mixes;",
             chars_sent);
    $display("%0d amounts checked, %0d parsed, %0d rejected.", strings_checked, strings_ok,
             strings_checked - strings_ok);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
